### rtl/core/tmv_pkg.sv
// ----------------------------------------------------------------------------
// tmv_pkg
// Shared types and constants of the dual-number triangular matrix-vector block.
// ----------------------------------------------------------------------------
package tmv_pkg;

  // Fixed field widths
  localparam int DATA_W    = 32;   // Q16.16 value width
  localparam int FRAC_BITS = 16;   // fraction bits of Q16.16
  localparam int ADDR_W    = 7;    // write address field
  localparam int ROW_W     = 4;    // result row field
  localparam int CFG_W     = 7;    // widest configuration register
  localparam int CFG_IDX_W = 2;    // configuration register index
  localparam int ORD_W     = 5;    // out_rows / matrix_order registers
  localparam int SKIP_W    = 7;    // row stride, grows by one per row
  localparam int POS_W     = 13;   // unwrapped packed row start

  // Command codes
  typedef enum logic [1:0] {
    OP_MAT_WR  = 2'd0,
    OP_VEC_WR  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NOP     = 2'd3
  } tmv_op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_ROWS     = 2'd0,
    CFG_MATRIX_ORDER = 2'd1,
    CFG_SEED_INDEX   = 2'd2,
    CFG_UNUSED       = 2'd3
  } tmv_cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_INIT,
    S_WRAP,
    S_MAC,
    S_SEED,
    S_DRAIN
  } tmv_state_t;

endpackage

### rtl/core/tmv_in_if.sv
// ----------------------------------------------------------------------------
// tmv_in_if
// Command channel: matrix/vector writes and compute requests.
// ----------------------------------------------------------------------------
interface tmv_in_if;
  import tmv_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] value_re;
  logic [DATA_W-1:0] value_du;

  modport source (output valid, output opcode, output addr, output value_re,
                  output value_du, input ready);
  modport sink   (input valid, input opcode, input addr, input value_re,
                  input value_du, output ready);
endinterface

### rtl/core/tmv_out_if.sv
// ----------------------------------------------------------------------------
// tmv_out_if
// Result channel: one transfer per result row.
// ----------------------------------------------------------------------------
interface tmv_out_if;
  import tmv_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  row;
  logic [DATA_W-1:0] out_re;
  logic [DATA_W-1:0] out_du;
  logic              saturated;
  logic              last;

  modport source (output valid, output row, output out_re, output out_du,
                  output saturated, output last, input ready);
  modport sink   (input valid, input row, input out_re, input out_du,
                  input saturated, input last, output ready);
endinterface

### rtl/core/triangular_matvec_dual_top.sv
// ----------------------------------------------------------------------------
// triangular_matvec_dual_top
// Packed lower-triangular matrix times dual vector, Q16.16, one shared MAC.
// ----------------------------------------------------------------------------
// A matrix write or vector write is captured, then its address is folded back
// below MATRIX_DEPTH (or MAX_ORDER) once per wrap before the store is written.
// A compute first sets up the stride and row start; then for row i the row
// start is folded below MATRIX_DEPTH, i+1 matrix/vector reads are issued, one
// per cycle, into the shared pair of 32x32 multipliers, the seed term is issued
// when the seeded entry lies in the row, and the three-stage
// read/multiply/accumulate pipe drains before the row result is rounded,
// saturated and loaded into the output register. The sequencer also waits
// while a previous row result is not taken. The block takes no command while
// a write or compute is in progress.
// ----------------------------------------------------------------------------
module triangular_matvec_dual_top #(
  parameter int MAX_ORDER    = 16,
  parameter int MATRIX_DEPTH = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tmv_in_if.sink                      in_chan,
  tmv_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [tmv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmv_pkg::CFG_W-1:0]   cfg_data
);
  import tmv_pkg::*;

  localparam int MAT_AW = $clog2(MATRIX_DEPTH);
  localparam int VEC_AW = $clog2(MAX_ORDER);
  localparam int RW     = $clog2(MAX_ORDER + 1);
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_ORDER) + 2;

  // Round toward minus infinity to Q16.16 and saturate; top bit flags a clip
  function automatic logic [DATA_W:0] acc_finish(input logic [ACC_W-1:0] acc);
    logic [ACC_W-FRAC_BITS-DATA_W:0] hi;
    logic                            ok;
    hi = acc[ACC_W-1:FRAC_BITS+DATA_W-1];
    ok = (hi == '0) || (hi == '1);
    if (ok) begin
      acc_finish = {1'b0, acc[FRAC_BITS+DATA_W-1:FRAC_BITS]};
    end else if (acc[ACC_W-1]) begin
      acc_finish = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      acc_finish = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // Configuration registers
  logic [ORD_W-1:0]  cfg_out_rows_r;
  logic [ORD_W-1:0]  cfg_order_r;
  logic [ADDR_W-1:0] cfg_seed_r;

  // Sequencer and row bookkeeping
  tmv_state_t        state_r, state_nxt;
  logic [1:0]        wr_op_r;
  logic [ADDR_W-1:0] red_r;
  logic [DATA_W-1:0] wr_re_r;
  logic [DATA_W-1:0] wr_du_r;
  logic [RW-1:0]     rows_r;
  logic [RW-1:0]     row_r;
  logic [RW-1:0]     col_r;
  logic [SKIP_W-1:0] skip_r;
  logic [POS_W-1:0]  start_r;
  logic [POS_W-1:0]  base_r;
  logic [MAT_AW-1:0] ptr_r;

  // Stores
  logic [DATA_W-1:0] mat_mem [MATRIX_DEPTH];
  logic [DATA_W-1:0] vre_mem [MAX_ORDER];
  logic [DATA_W-1:0] vdu_mem [MAX_ORDER];

  // MAC pipeline
  logic                     v1_r, sd1_r, v2_r;
  logic [DATA_W-1:0]        mat_q_r, vre_q_r, vdu_q_r;
  logic signed [PROD_W-1:0] prod_re_r, prod_du_r;
  logic [ACC_W-1:0]         acc_re_r, acc_du_r;

  // Output register
  logic              out_valid_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [DATA_W-1:0] out_re_r, out_du_r;
  logic              out_sat_r, out_last_r;

  // Decoded control
  logic              in_xfer;
  logic [RW-1:0]     rows_cap;
  logic [SKIP_W-1:0] skip0;
  logic [13:0]       tri_w;
  logic [POS_W-1:0]  start0;
  logic              wr_fold;
  logic              base_fold;
  logic              seed_hit;
  logic [POS_W-1:0]  seed_off;
  logic [VEC_AW-1:0] vre_raddr;
  logic              out_free;
  logic              row_done;
  logic              last_row;
  logic              mat_we, vec_we;
  logic [DATA_W:0]   fin_re, fin_du;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  // Rows clipped to the store size; first stride clamped to at least one
  assign rows_cap = (32'(cfg_out_rows_r) > 32'(MAX_ORDER)) ? RW'(MAX_ORDER)
                                                            : RW'(cfg_out_rows_r);
  assign skip0    = (8'(cfg_order_r) > 8'(rows_cap))
                    ? SKIP_W'(8'(cfg_order_r) - 8'(rows_cap)) : SKIP_W'(1);
  assign tri_w    = 14'(skip_r) * 14'(skip_r + SKIP_W'(1));
  assign start0   = POS_W'(tri_w >> 1) - POS_W'(1);

  // Address folding against store depth
  assign wr_fold   = (wr_op_r == OP_MAT_WR) ? (32'(red_r) >= 32'(MATRIX_DEPTH))
                                            : (32'(red_r) >= 32'(MAX_ORDER));
  assign base_fold = 32'(base_r) >= 32'(MATRIX_DEPTH);

  // Seed term applies when the seeded entry lies in the current row
  assign seed_off  = POS_W'(cfg_seed_r) - start_r;
  assign seed_hit  = (start_r <= POS_W'(cfg_seed_r)) &&
                     (POS_W'(cfg_seed_r) <= start_r + POS_W'(row_r));
  assign vre_raddr = (state_r == S_SEED) ? seed_off[VEC_AW-1:0] : col_r[VEC_AW-1:0];

  assign out_free = !out_valid_r || out_chan.ready;
  assign row_done = (state_r == S_DRAIN) && !v1_r && !v2_r && out_free;
  assign last_row = (row_r == rows_r - RW'(1));

  assign mat_we = (state_r == S_WRITE) && !wr_fold && (wr_op_r == OP_MAT_WR);
  assign vec_we = (state_r == S_WRITE) && !wr_fold && (wr_op_r == OP_VEC_WR);

  assign fin_re = acc_finish(acc_re_r);
  assign fin_du = acc_finish(acc_du_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          priority if (in_chan.opcode == OP_MAT_WR || in_chan.opcode == OP_VEC_WR) begin
            state_nxt = S_WRITE;
          end else if (in_chan.opcode == OP_COMPUTE && rows_cap != '0) begin
            state_nxt = S_INIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_WRITE: if (!wr_fold) state_nxt = S_IDLE;
      S_INIT:  state_nxt = S_WRAP;
      S_WRAP:  if (!base_fold) state_nxt = S_MAC;
      S_MAC:   if (col_r == row_r) state_nxt = S_SEED;
      S_SEED:  state_nxt = S_DRAIN;
      S_DRAIN: if (row_done) state_nxt = last_row ? S_IDLE : S_WRAP;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cfg_out_rows_r <= ORD_W'(15);
      cfg_order_r    <= ORD_W'(16);
      cfg_seed_r     <= '0;
      v1_r           <= 1'b0;
      sd1_r          <= 1'b0;
      v2_r           <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OUT_ROWS:     cfg_out_rows_r <= cfg_data[ORD_W-1:0];
          CFG_MATRIX_ORDER: cfg_order_r    <= cfg_data[ORD_W-1:0];
          CFG_SEED_INDEX:   cfg_seed_r     <= cfg_data[ADDR_W-1:0];
          default: ;
        endcase
      end
      v1_r  <= (state_r == S_MAC) || ((state_r == S_SEED) && seed_hit);
      sd1_r <= (state_r == S_SEED);
      v2_r  <= v1_r;
      if (row_done) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        wr_op_r <= in_chan.opcode;
        red_r   <= in_chan.addr;
        wr_re_r <= in_chan.value_re;
        wr_du_r <= in_chan.value_du;
        rows_r  <= rows_cap;
        skip_r  <= skip0;
        row_r   <= '0;
      end
      S_WRITE: begin
        if (wr_fold) begin
          red_r <= (wr_op_r == OP_MAT_WR) ? red_r - ADDR_W'(MATRIX_DEPTH)
                                          : red_r - ADDR_W'(MAX_ORDER);
        end
      end
      S_INIT: begin
        start_r <= start0;
        base_r  <= start0;
      end
      S_WRAP: begin
        if (base_fold) begin
          base_r <= base_r - POS_W'(MATRIX_DEPTH);
        end else begin
          ptr_r    <= base_r[MAT_AW-1:0];
          col_r    <= '0;
          acc_re_r <= '0;
          acc_du_r <= '0;
        end
      end
      S_MAC: begin
        ptr_r <= (32'(ptr_r) == MATRIX_DEPTH - 1) ? '0 : ptr_r + MAT_AW'(1);
        col_r <= col_r + RW'(1);
      end
      S_SEED: ;
      S_DRAIN: begin
        if (row_done) begin
          row_r   <= row_r + RW'(1);
          start_r <= start_r + POS_W'(skip_r);
          base_r  <= base_r + POS_W'(skip_r);
          skip_r  <= skip_r + SKIP_W'(1);
        end
      end
      default: ;
    endcase

    // Accumulate stage
    if (v2_r) begin
      acc_re_r <= acc_re_r + {{(ACC_W-PROD_W){prod_re_r[PROD_W-1]}}, prod_re_r};
      acc_du_r <= acc_du_r + {{(ACC_W-PROD_W){prod_du_r[PROD_W-1]}}, prod_du_r};
    end

    // Multiply stage; the seed beat passes the value element scaled to Q32.32
    if (sd1_r) begin
      prod_re_r <= '0;
      prod_du_r <= {{(PROD_W-DATA_W-FRAC_BITS){vre_q_r[DATA_W-1]}}, vre_q_r,
                    {FRAC_BITS{1'b0}}};
    end else begin
      prod_re_r <= $signed(mat_q_r) * $signed(vre_q_r);
      prod_du_r <= $signed(mat_q_r) * $signed(vdu_q_r);
    end

    // Result row into the output register
    if (row_done) begin
      out_row_r  <= ROW_W'(row_r);
      out_re_r   <= fin_re[DATA_W-1:0];
      out_du_r   <= fin_du[DATA_W-1:0];
      out_sat_r  <= fin_re[DATA_W] || fin_du[DATA_W];
      out_last_r <= last_row;
    end
  end

  // Matrix store
  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[MAT_AW'(red_r)] <= wr_re_r;
    end
    mat_q_r <= mat_mem[ptr_r];
  end

  // Vector stores
  always_ff @(posedge clk) begin
    if (vec_we) begin
      vre_mem[VEC_AW'(red_r)] <= wr_re_r;
    end
    vre_q_r <= vre_mem[vre_raddr];
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vdu_mem[VEC_AW'(red_r)] <= wr_du_r;
    end
    vdu_q_r <= vdu_mem[col_r[VEC_AW-1:0]];
  end

  // Result channel
  assign out_chan.valid     = out_valid_r;
  assign out_chan.row       = out_row_r;
  assign out_chan.out_re    = out_re_r;
  assign out_chan.out_du    = out_du_r;
  assign out_chan.saturated = out_sat_r;
  assign out_chan.last      = out_last_r;

endmodule

### sim/triangular_matvec_dual_top_tb.sv
// ----------------------------------------------------------------------------
// triangular_matvec_dual_top_tb
// Self-checking bench for the dual-number triangular matrix-vector block.
// Every matrix and vector entry is loaded first. Then come directed commands
// (field extremes, wrapped addresses, clamped row counts and strides, seed in
// and out of a row, saturation) and random traffic under several flow-control
// phases. A scoreboard class keeps its own copy of the stores and registers
// and checks every result row field by field.
// ----------------------------------------------------------------------------
module triangular_matvec_dual_top_tb;
  import tmv_pkg::*;

  localparam int MAT_DEPTH   = 128;
  localparam int VEC_DEPTH   = 16;
  localparam int QUIET_WAIT  = 64;    // settle time before a register write
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int IDLE_LIMIT  = 4000;  // watchdog, cycles without a transfer
  localparam int PHASE_ITEMS = 22;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // One row result as seen on the output channel
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] du;
    logic              saturated;
    logic              last;
  } row_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow stores, shadow registers, queue of expected rows
  // --------------------------------------------------------------------------
  class matvec_scoreboard;
    logic [31:0]  mat_mem [MAT_DEPTH];
    logic [31:0]  vec_re  [VEC_DEPTH];
    logic [31:0]  vec_du  [VEC_DEPTH];
    logic [4:0]   rows_reg;
    logic [4:0]   order_reg;
    logic [6:0]   seed_reg;
    row_result_t  expected_rows[$];
    int           errors;

    function new();
      foreach (mat_mem[k]) mat_mem[k] = '0;
      foreach (vec_re[k]) begin
        vec_re[k] = '0;
        vec_du[k] = '0;
      end
      rows_reg  = 5'd15;
      order_reg = 5'd16;
      seed_reg  = 7'd0;
      errors    = 0;
    endfunction

    function void set_reg(tmv_cfg_idx_t idx, logic [CFG_W-1:0] d);
      case (idx)
        CFG_OUT_ROWS:     rows_reg  = d[4:0];
        CFG_MATRIX_ORDER: order_reg = d[4:0];
        CFG_SEED_INDEX:   seed_reg  = d[6:0];
        default: ;
      endcase
    endfunction

    // Floor to Q16.16 and clip to 32 bits; bit 32 flags a clip
    function logic [32:0] round_clip(logic signed [79:0] acc);
      longint v;
      v = longint'(acc >>> FRAC_BITS);
      if (v > 64'sd2147483647) return {1'b1, Q_MAX};
      if (v < -64'sd2147483648) return {1'b1, Q_MIN};
      return {1'b0, v[31:0]};
    endfunction

    // Update shadow state for an accepted command, queue the rows it yields
    function void take_command(tmv_op_t op, logic [ADDR_W-1:0] a,
                               logic [31:0] re, logic [31:0] du);
      int                 rows, stride, start, i, j;
      logic signed [79:0] acc_re, acc_du, m, x;
      logic [32:0]        fin_re, fin_du;
      row_result_t        r;
      case (op)
        OP_MAT_WR: mat_mem[a % MAT_DEPTH] = re;
        OP_VEC_WR: begin
          vec_re[a % VEC_DEPTH] = re;
          vec_du[a % VEC_DEPTH] = du;
        end
        OP_COMPUTE: begin
          rows   = (rows_reg > VEC_DEPTH) ? VEC_DEPTH : int'(rows_reg);
          stride = (int'(order_reg) > rows) ? int'(order_reg) - rows : 1;
          start  = stride * (stride + 1) / 2 - 1;
          for (i = 0; i < rows; i++) begin
            acc_re = '0;
            acc_du = '0;
            for (j = 0; j <= i; j++) begin
              m = $signed(mat_mem[(start + j) % MAT_DEPTH]);
              x = $signed(vec_re[j % VEC_DEPTH]);
              acc_re += m * x;
              x = $signed(vec_du[j % VEC_DEPTH]);
              acc_du += m * x;
            end
            // seeded entry inside this row: add the matching value element
            if (start <= int'(seed_reg) && int'(seed_reg) <= start + i) begin
              x = $signed(vec_re[(int'(seed_reg) - start) % VEC_DEPTH]);
              acc_du += x <<< FRAC_BITS;
            end
            fin_re      = round_clip(acc_re);
            fin_du      = round_clip(acc_du);
            r.row       = i[ROW_W-1:0];
            r.re        = fin_re[31:0];
            r.du        = fin_du[31:0];
            r.saturated = fin_re[32] | fin_du[32];
            r.last      = (i + 1 == rows);
            expected_rows.push_back(r);
            start  += stride;
            stride += 1;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH %s", msg);
      errors++;
    endtask

    task check_row(row_result_t got);
      row_result_t want;
      if (expected_rows.size() == 0) begin
        report($sformatf("unexpected row %0d re=%h du=%h", got.row, got.re, got.du));
        return;
      end
      want = expected_rows.pop_front();
      if (got.row !== want.row || got.re !== want.re || got.du !== want.du ||
          got.saturated !== want.saturated || got.last !== want.last)
        report($sformatf("row %0d/%0d re %h/%h du %h/%h sat %b/%b last %b/%b",
                         got.row, want.row, got.re, want.re, got.du, want.du,
                         got.saturated, want.saturated, got.last, want.last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  tmv_in_if  in_if ();
  tmv_out_if out_if ();

  matvec_scoreboard sb;

  int src_gap_pct;    // sender idle probability per cycle
  int sink_stall_pct; // receiver stall probability per cycle
  int hold_len;       // set by the stimulus, cleared by the receiver
  int idle_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  triangular_matvec_dual_top #(
    .MAX_ORDER    (VEC_DEPTH),
    .MATRIX_DEPTH (MAT_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    row_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.row       = out_if.row;
      got.re        = out_if.out_re;
      got.du        = out_if.out_du;
      got.saturated = out_if.saturated;
      got.last      = out_if.last;
      sb.check_row(got);
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("triangular_matvec_dual_top_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------

  // Q16.16 word: mostly small magnitudes, some full-range, some extremes
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  // One command transfer, with a random gap in front of it
  task automatic send_cmd(tmv_op_t op, logic [ADDR_W-1:0] a,
                          logic [31:0] re, logic [31:0] du);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_gap_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.opcode   <= op;
    in_if.addr     <= a;
    in_if.value_re <= re;
    in_if.value_du <= du;
    do @(posedge clk); while (!in_if.ready);
    sb.take_command(op, a, re, du);
  endtask

  // Sender pauses until every expected row is in and the block has settled
  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    while (sb.expected_rows.size() != 0) @(posedge clk);
    repeat (QUIET_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(tmv_cfg_idx_t idx, logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  // Unused upper data bits of the 5-bit registers get random values
  task automatic apply_config(int rows, int order, int seed);
    wait_quiet();
    write_reg(CFG_OUT_ROWS, {2'($urandom_range(3)), 5'(rows)});
    write_reg(CFG_MATRIX_ORDER, {2'($urandom_range(3)), 5'(order)});
    write_reg(CFG_SEED_INDEX, 7'(seed));
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    int r, rows, order, seed;
    r = $urandom_range(99);
    if (r < 70)      rows = $urandom_range(1, 5);
    else if (r < 82) rows = $urandom_range(6, 16);
    else if (r < 90) rows = 16;
    else if (r < 95) rows = 0;
    else             rows = $urandom_range(17, 31);
    r = $urandom_range(99);
    if (r < 60)      order = $urandom_range(0, 31);
    else if (r < 80) order = 16;
    else if (r < 90) order = 31;
    else             order = 2;
    r = $urandom_range(99);
    if (r < 50)      seed = $urandom_range(0, 30);
    else if (r < 95) seed = $urandom_range(0, 127);
    else             seed = 127;
    apply_config(rows, order, seed);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int      k, n, p, r;
    tmv_op_t op;

    sb = new();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    hold_len       = 0;
    idle_cycles    = 0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_OUT_ROWS;
    cfg_data       <= '0;
    in_if.valid    <= 1'b0;
    in_if.opcode   <= OP_NOP;
    in_if.addr     <= '0;
    in_if.value_re <= '0;
    in_if.value_du <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every vector element and matrix entry before any compute
    for (k = 0; k < VEC_DEPTH; k++) send_cmd(OP_VEC_WR, 7'(k), rand_word(), rand_word());
    for (k = 0; k < MAT_DEPTH; k++) send_cmd(OP_MAT_WR, 7'(k), rand_word(), rand_word());

    // Directed: field extremes, wrapped addresses, ignored opcode
    send_cmd(OP_VEC_WR, 7'd127, Q_MAX, Q_MIN);      // wraps to element 15
    send_cmd(OP_VEC_WR, 7'd0, Q_MIN, Q_MAX);
    send_cmd(OP_MAT_WR, 7'd127, Q_MAX, Q_MIN);      // du ignored
    send_cmd(OP_MAT_WR, 7'd64, Q_MIN, 32'h0);
    send_cmd(OP_NOP, 7'd85, $urandom, $urandom);
    send_cmd(OP_COMPUTE, 7'd0, 32'h0, 32'h0);      // reset settings

    // Unused register index: no effect expected
    wait_quiet();
    write_reg(CFG_UNUSED, 7'h7f);
    cfg_we <= 1'b0;

    // Order not above row count: stride clamps to one
    apply_config(16, 16, 0);
    send_cmd(OP_COMPUTE, 7'h7f, Q_MAX, Q_MAX);
    // Zero rows: no result
    apply_config(0, 16, 5);
    send_cmd(OP_COMPUTE, 7'd0, 32'h0, 32'h0);
    // Row count above the maximum saturates
    apply_config(31, 2, 127);
    send_cmd(OP_COMPUTE, 7'd0, 32'h0, 32'h0);
    // Large stride: row start far beyond the matrix store
    apply_config(1, 31, 127);
    send_cmd(OP_COMPUTE, 7'd0, 32'h0, 32'h0);
    apply_config(3, 20, 120);
    send_cmd(OP_COMPUTE, 7'd0, 32'h0, 32'h0);

    // Saturation both ways, seed on the first entry
    apply_config(2, 2, 0);
    send_cmd(OP_MAT_WR, 7'd0, Q_MAX, 32'h0);
    send_cmd(OP_VEC_WR, 7'd0, Q_MAX, Q_MIN);
    send_cmd(OP_COMPUTE, 7'd0, 32'h0, 32'h0);
    send_cmd(OP_MAT_WR, 7'd0, Q_MIN, 32'h0);
    send_cmd(OP_COMPUTE, 7'd0, 32'h0, 32'h0);

    // Seed inside the third row
    apply_config(4, 4, 5);
    send_cmd(OP_VEC_WR, 7'd66, rand_word(), rand_word());   // wraps to element 2
    send_cmd(OP_COMPUTE, 7'd0, 32'h0, 32'h0);

    // Long receiver hold-off while the sender keeps offering
    apply_config(16, 16, 3);
    hold_len = HOLD_CYCLES;
    send_cmd(OP_COMPUTE, 7'd0, 32'h0, 32'h0);
    send_cmd(OP_COMPUTE, 7'd0, 32'h0, 32'h0);
    send_cmd(OP_MAT_WR, 7'd9, rand_word(), rand_word());
    send_cmd(OP_COMPUTE, 7'd0, 32'h0, 32'h0);

    // Random traffic over flow-control phases
    for (p = 0; p < 8; p++) begin
      random_config();
      case (p % 4)
        0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_gap_pct = 74; sink_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  sink_stall_pct = 74; end
        default: begin src_gap_pct = 22; sink_stall_pct = 22; end
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 40)      op = OP_MAT_WR;
        else if (r < 60) op = OP_VEC_WR;
        else if (r < 95) op = OP_COMPUTE;
        else             op = OP_NOP;
        send_cmd(op, 7'($urandom_range(127)), rand_word(), rand_word());
        if (op != OP_NOP) n++;
      end
    end

    // Drain and finish
    wait_quiet();
    if (sb.errors == 0 && sb.expected_rows.size() == 0) begin
      $display("triangular_matvec_dual_top_tb: clean");
    end else begin
      $display("triangular_matvec_dual_top_tb: errors");
    end
    $finish;
  end

endmodule
